/* rtl/pbl_pkg.sv */
// ----------------------------------------------------------------------------
// pbl_pkg
// Shared widths, request and status codes, and the controller/datapath
// command and status bundles of the page buffer tag controller.
// ----------------------------------------------------------------------------
`default_nettype none

package pbl_pkg;

  localparam int KIND_W   = 3;
  localparam int FILE_W   = 16;
  localparam int PAGE_W   = 32;
  localparam int SLOT_W   = 4;
  localparam int STATUS_W = 3;
  localparam int STAMP_W  = 32;
  localparam int ACT_W    = 5;

  localparam logic [ACT_W-1:0] ACT_RESET = 5'd16;

  // request kinds
  localparam logic [KIND_W-1:0] K_READ   = 3'd0;
  localparam logic [KIND_W-1:0] K_WRITE  = 3'd1;
  localparam logic [KIND_W-1:0] K_FLUSH  = 3'd2;
  localparam logic [KIND_W-1:0] K_PIN    = 3'd3;
  localparam logic [KIND_W-1:0] K_UNPIN  = 3'd4;
  localparam logic [KIND_W-1:0] K_REMOVE = 3'd5;

  // result status
  localparam logic [STATUS_W-1:0] ST_HIT    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FILL   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EVICT  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ABSENT = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ALLPIN = 3'd4;

  typedef struct packed {
    logic load;    // latch request, restart scan
    logic scan;    // step the slot scan
    logic commit;  // apply update, load result register
  } pbl_cmd_t;

  typedef struct packed {
    logic scan_done;
  } pbl_sts_t;

endpackage

`default_nettype wire

/* rtl/pbl_ram.sv */
// ----------------------------------------------------------------------------
// pbl_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module pbl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

/* rtl/pbl_ctrl.sv */
// ----------------------------------------------------------------------------
// pbl_ctrl
// Request sequencer: accept, scan the slots, commit and hand the result to
// the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pbl_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire pbl_pkg::pbl_sts_t sts,
  output pbl_pkg::pbl_cmd_t      cmd
);
  import pbl_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_COMMIT = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        // result register must be free or emptying this cycle
        if (!out_valid_r || out_ready) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

/* rtl/pbl_dp.sv */
// ----------------------------------------------------------------------------
// pbl_dp
// Slot state, tag and use-stamp RAMs, one-slot-per-cycle scan trackers,
// commit logic and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pbl_dp #(
  parameter int SLOTS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [pbl_pkg::ACT_W-1:0]     cfg_wr_data,
  input  wire logic [pbl_pkg::KIND_W-1:0]    in_kind,
  input  wire logic [pbl_pkg::FILE_W-1:0]    in_file_id,
  input  wire logic [pbl_pkg::PAGE_W-1:0]    in_page_id,
  input  wire pbl_pkg::pbl_cmd_t             cmd,
  output pbl_pkg::pbl_sts_t                  sts,
  output logic [pbl_pkg::SLOT_W-1:0]         out_slot,
  output logic [pbl_pkg::STATUS_W-1:0]       out_status,
  output logic                               out_fetch_needed,
  output logic                               out_write_back_needed,
  output logic [pbl_pkg::FILE_W-1:0]         out_write_back_file,
  output logic [pbl_pkg::PAGE_W-1:0]         out_write_back_page
);
  import pbl_pkg::*;

  localparam int IW  = $clog2(SLOTS);
  localparam int CW0 = $clog2(SLOTS + 1);
  localparam int KW  = (CW0 > ACT_W) ? CW0 : ACT_W;
  localparam int TW  = FILE_W + PAGE_W;

  // configuration
  logic [ACT_W-1:0] active_r;
  logic [KW-1:0]    act_k, n_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= ACT_RESET;
    end else if (cfg_wr_en) begin
      active_r <= cfg_wr_data;
    end
  end

  assign act_k = KW'(active_r);
  assign n_eff = (act_k == '0) ? KW'(1) :
                 (act_k > KW'(SLOTS)) ? KW'(SLOTS) : act_k;

  // request
  logic [KIND_W-1:0] req_kind_r;
  logic [FILE_W-1:0] req_file_r;
  logic [PAGE_W-1:0] req_page_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_kind_r <= in_kind;
      req_file_r <= in_file_id;
      req_page_r <= in_page_id;
    end
  end

  // slot state
  logic [SLOTS-1:0]   valid_r, valid_nxt;
  logic [SLOTS-1:0]   pin_r, pin_nxt;
  logic [SLOTS-1:0]   dirty_r, dirty_nxt;
  logic [STAMP_W-1:0] use_clock_r, use_clock_nxt;

  // scan
  logic [KW-1:0]      issue_cnt_r, issue_cnt_nxt;
  logic               pend_r, pend_nxt;
  logic [IW-1:0]      pend_idx_r, pend_idx_nxt;
  logic               issue;
  logic [IW-1:0]      rd_addr;
  logic [TW-1:0]      rd_tag;
  logic [STAMP_W-1:0] rd_stamp;
  logic [STAMP_W-1:0] age;
  logic               match;

  logic               hit_found_r, hit_found_nxt;
  logic [IW-1:0]      hit_idx_r, hit_idx_nxt;
  logic               empty_found_r, empty_found_nxt;
  logic [IW-1:0]      empty_idx_r, empty_idx_nxt;
  logic               vic_found_r, vic_found_nxt;
  logic [IW-1:0]      vic_idx_r, vic_idx_nxt;
  logic [STAMP_W-1:0] vic_age_r, vic_age_nxt;
  logic [TW-1:0]      vic_tag_r, vic_tag_nxt;

  assign issue   = cmd.scan && (issue_cnt_r < n_eff);
  assign rd_addr = issue_cnt_r[IW-1:0];
  assign age     = use_clock_r - rd_stamp;
  assign match   = valid_r[pend_idx_r] && (rd_tag == {req_file_r, req_page_r});

  assign sts.scan_done = (issue_cnt_r == n_eff) && !pend_r;

  always_comb begin
    issue_cnt_nxt   = issue_cnt_r;
    pend_nxt        = 1'b0;
    pend_idx_nxt    = pend_idx_r;
    hit_found_nxt   = hit_found_r;
    hit_idx_nxt     = hit_idx_r;
    empty_found_nxt = empty_found_r;
    empty_idx_nxt   = empty_idx_r;
    vic_found_nxt   = vic_found_r;
    vic_idx_nxt     = vic_idx_r;
    vic_age_nxt     = vic_age_r;
    vic_tag_nxt     = vic_tag_r;
    if (cmd.load) begin
      issue_cnt_nxt   = '0;
      hit_found_nxt   = 1'b0;
      empty_found_nxt = 1'b0;
      vic_found_nxt   = 1'b0;
    end else begin
      if (issue) begin
        issue_cnt_nxt = issue_cnt_r + KW'(1);
        pend_nxt      = 1'b1;
        pend_idx_nxt  = rd_addr;
      end
      if (pend_r) begin
        if (match && !hit_found_r) begin
          hit_found_nxt = 1'b1;
          hit_idx_nxt   = pend_idx_r;
        end
        if (!valid_r[pend_idx_r] && !empty_found_r) begin
          empty_found_nxt = 1'b1;
          empty_idx_nxt   = pend_idx_r;
        end
        // oldest unpinned slot; strict compare keeps the lowest index on ties
        if (!pin_r[pend_idx_r] && (!vic_found_r || age > vic_age_r)) begin
          vic_found_nxt = 1'b1;
          vic_idx_nxt   = pend_idx_r;
          vic_age_nxt   = age;
          vic_tag_nxt   = rd_tag;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_cnt_r   <= '0;
      pend_r        <= 1'b0;
      hit_found_r   <= 1'b0;
      empty_found_r <= 1'b0;
      vic_found_r   <= 1'b0;
    end else begin
      issue_cnt_r   <= issue_cnt_nxt;
      pend_r        <= pend_nxt;
      hit_found_r   <= hit_found_nxt;
      empty_found_r <= empty_found_nxt;
      vic_found_r   <= vic_found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_idx_r  <= pend_idx_nxt;
    hit_idx_r   <= hit_idx_nxt;
    empty_idx_r <= empty_idx_nxt;
    vic_idx_r   <= vic_idx_nxt;
    vic_age_r   <= vic_age_nxt;
    vic_tag_r   <= vic_tag_nxt;
  end

  // commit
  logic                c_rw, c_fill, c_stamp;
  logic [IW-1:0]       c_slot;
  logic [STATUS_W-1:0] c_status;
  logic                c_fetch, c_wb;
  logic [TW-1:0]       c_wb_tag;

  always_comb begin
    c_rw      = (req_kind_r == K_READ) || (req_kind_r == K_WRITE);
    c_fill    = 1'b0;
    c_stamp   = 1'b0;
    c_slot    = '0;
    c_status  = ST_ABSENT;
    c_fetch   = 1'b0;
    c_wb      = 1'b0;
    c_wb_tag  = '0;
    valid_nxt = valid_r;
    pin_nxt   = pin_r;
    dirty_nxt = dirty_r;
    if (c_rw) begin
      if (hit_found_r) begin
        c_slot   = hit_idx_r;
        c_status = ST_HIT;
        c_stamp  = 1'b1;
      end else if (empty_found_r) begin
        c_slot   = empty_idx_r;
        c_status = ST_FILL;
        c_fill   = 1'b1;
      end else if (vic_found_r) begin
        c_slot   = vic_idx_r;
        c_status = ST_EVICT;
        c_fill   = 1'b1;
        c_wb     = 1'b1;
        c_wb_tag = vic_tag_r;
      end else begin
        c_status = ST_ALLPIN;
      end
      if (c_fill) begin
        c_stamp           = 1'b1;
        c_fetch           = 1'b1;
        valid_nxt[c_slot] = 1'b1;
        pin_nxt[c_slot]   = 1'b0;
        dirty_nxt[c_slot] = 1'b0;
      end
      if (req_kind_r == K_WRITE && c_status != ST_ALLPIN) begin
        dirty_nxt[c_slot] = 1'b1;
      end
    end else if (hit_found_r) begin
      c_slot   = hit_idx_r;
      case (req_kind_r)
        K_FLUSH: begin
          c_status          = ST_HIT;
          c_wb              = 1'b1;
          c_wb_tag          = {req_file_r, req_page_r};
          dirty_nxt[c_slot] = 1'b0;
        end
        K_PIN: begin
          c_status        = ST_HIT;
          pin_nxt[c_slot] = 1'b1;
        end
        K_UNPIN: begin
          c_status        = ST_HIT;
          pin_nxt[c_slot] = 1'b0;
        end
        K_REMOVE: begin
          c_status          = ST_HIT;
          valid_nxt[c_slot] = 1'b0;
          pin_nxt[c_slot]   = 1'b0;
          dirty_nxt[c_slot] = 1'b0;
        end
        default: begin
          c_slot = '0;
        end
      endcase
    end
    use_clock_nxt = c_stamp ? (use_clock_r + STAMP_W'(1)) : use_clock_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      pin_r       <= '0;
      dirty_r     <= '0;
      use_clock_r <= '0;
    end else if (cmd.commit) begin
      valid_r     <= valid_nxt;
      pin_r       <= pin_nxt;
      dirty_r     <= dirty_nxt;
      use_clock_r <= use_clock_nxt;
    end
  end

  pbl_ram #(.WIDTH(TW), .DEPTH(SLOTS)) u_tag_ram (
    .clk     (clk),
    .wr_en   (cmd.commit && c_fill),
    .wr_addr (c_slot),
    .wr_data ({req_file_r, req_page_r}),
    .rd_addr (rd_addr),
    .rd_data (rd_tag)
  );

  pbl_ram #(.WIDTH(STAMP_W), .DEPTH(SLOTS)) u_stamp_ram (
    .clk     (clk),
    .wr_en   (cmd.commit && c_stamp),
    .wr_addr (c_slot),
    .wr_data (use_clock_r),
    .rd_addr (rd_addr),
    .rd_data (rd_stamp)
  );

  // result register
  logic [SLOT_W-1:0]   out_slot_r;
  logic [STATUS_W-1:0] out_status_r;
  logic                out_fetch_r, out_wb_r;
  logic [TW-1:0]       out_wb_tag_r;

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_slot_r   <= SLOT_W'(c_slot);
      out_status_r <= c_status;
      out_fetch_r  <= c_fetch;
      out_wb_r     <= c_wb;
      out_wb_tag_r <= c_wb_tag;
    end
  end

  assign out_slot              = out_slot_r;
  assign out_status            = out_status_r;
  assign out_fetch_needed      = out_fetch_r;
  assign out_write_back_needed = out_wb_r;
  assign out_write_back_file   = out_wb_tag_r[TW-1:PAGE_W];
  assign out_write_back_page   = out_wb_tag_r[PAGE_W-1:0];

endmodule

`default_nettype wire

/* rtl/page_buffer_lru_pin_dirty.sv */
// ----------------------------------------------------------------------------
// page_buffer_lru_pin_dirty
// Tag and LRU replacement control of a page buffer pool with pin and dirty.
// ----------------------------------------------------------------------------
// A request is served by a scan of the tag and use-stamp RAMs over the n active
// slots through their single read port, one slot per cycle; a new request is
// accepted only after the previous one has committed.
// A result waiting in the output register does not block the next accept.
// Reset: all slots empty, unpinned and clean, use counter 0, 16 active slots.
`default_nettype none

module page_buffer_lru_pin_dirty #(
  parameter int SLOTS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [pbl_pkg::ACT_W-1:0]     cfg_wr_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [pbl_pkg::KIND_W-1:0]    in_kind,
  input  wire logic [pbl_pkg::FILE_W-1:0]    in_file_id,
  input  wire logic [pbl_pkg::PAGE_W-1:0]    in_page_id,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [pbl_pkg::SLOT_W-1:0]         out_slot,
  output logic [pbl_pkg::STATUS_W-1:0]       out_status,
  output logic                               out_fetch_needed,
  output logic                               out_write_back_needed,
  output logic [pbl_pkg::FILE_W-1:0]         out_write_back_file,
  output logic [pbl_pkg::PAGE_W-1:0]         out_write_back_page
);
  import pbl_pkg::*;

  pbl_cmd_t cmd;
  pbl_sts_t sts;

  pbl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pbl_dp #(.SLOTS(SLOTS)) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_wr_data           (cfg_wr_data),
    .in_kind               (in_kind),
    .in_file_id            (in_file_id),
    .in_page_id            (in_page_id),
    .cmd                   (cmd),
    .sts                   (sts),
    .out_slot              (out_slot),
    .out_status            (out_status),
    .out_fetch_needed      (out_fetch_needed),
    .out_write_back_needed (out_write_back_needed),
    .out_write_back_file   (out_write_back_file),
    .out_write_back_page   (out_write_back_page)
  );

  // one request in flight: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while scan in progress");

  a_commit_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid)
    else $error("commit did not present a result");

  a_allpin_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_ALLPIN |->
      out_slot == '0 && !out_fetch_needed && !out_write_back_needed)
    else $error("all-pinned result carries a slot or transfer");

  a_wb_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_write_back_needed |->
      out_status == ST_EVICT || out_status == ST_HIT)
    else $error("write-back on a result that is neither evict nor flush");

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the page buffer tag and LRU replacement controller.
// A directed table hits fill, hit, eviction, all-pinned, miss and slot count
// corner cases, then random request streams run over several slot counts.
// Results are checked against an in-bench slot table model or row values.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pbl_pkg::*;

  localparam int NSLOT = 16;
  localparam int POOL_N = 32;
  localparam int PHASE_REQS = 100;

  // kinds the block does not define
  localparam logic [KIND_W-1:0] K_UNDEF_LO = 3'd6;
  localparam logic [KIND_W-1:0] K_UNDEF_HI = 3'd7;

  typedef struct packed {
    logic [SLOT_W-1:0]   slot;
    logic [STATUS_W-1:0] status;
    logic                fetch;
    logic                wb;
    logic [FILE_W-1:0]   wb_file;
    logic [PAGE_W-1:0]   wb_page;
  } pool_reply_t;

  typedef struct {
    bit                is_cfg;
    logic [ACT_W-1:0]  act;
    logic [KIND_W-1:0] kind;
    logic [FILE_W-1:0] file;
    logic [PAGE_W-1:0] page;
    bit                typed;
    pool_reply_t       want;
  } plan_row_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_wr_en;
  logic [ACT_W-1:0]    cfg_wr_data;
  logic                in_valid;
  logic                in_ready;
  logic [KIND_W-1:0]   in_kind;
  logic [FILE_W-1:0]   in_file_id;
  logic [PAGE_W-1:0]   in_page_id;
  logic                out_valid;
  logic                out_ready;
  logic [SLOT_W-1:0]   out_slot;
  logic [STATUS_W-1:0] out_status;
  logic                out_fetch_needed;
  logic                out_write_back_needed;
  logic [FILE_W-1:0]   out_write_back_file;
  logic [PAGE_W-1:0]   out_write_back_page;

  // model of the slot table
  logic                slot_used   [NSLOT];
  logic [FILE_W-1:0]   slot_file   [NSLOT];
  logic [PAGE_W-1:0]   slot_page   [NSLOT];
  logic                slot_pinned [NSLOT];
  logic                slot_dirty  [NSLOT];
  logic [STAMP_W-1:0]  slot_stamp  [NSLOT];
  logic [STAMP_W-1:0]  use_count;
  logic [ACT_W-1:0]    active_cfg;

  pool_reply_t         pending_replies[$];
  plan_row_t           directed_plan[$];
  logic [FILE_W-1:0]   pool_file_ids[POOL_N];
  logic [PAGE_W-1:0]   pool_page_ids[POOL_N];
  int                  mismatches = 0;
  bit                  no_gaps = 1'b0;
  int                  hold_off = 0;

  page_buffer_lru_pin_dirty #(.SLOTS(NSLOT)) u_top (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_wr_data           (cfg_wr_data),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_kind               (in_kind),
    .in_file_id            (in_file_id),
    .in_page_id            (in_page_id),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_slot              (out_slot),
    .out_status            (out_status),
    .out_fetch_needed      (out_fetch_needed),
    .out_write_back_needed (out_write_back_needed),
    .out_write_back_file   (out_write_back_file),
    .out_write_back_page   (out_write_back_page)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic int slots_in_use();
    int n;
    n = int'(active_cfg);
    if (n < 1) n = 1;
    if (n > NSLOT) n = NSLOT;
    return n;
  endfunction

  // Applies one request to the slot table and returns the reply it produces.
  function automatic pool_reply_t serve_page_request(input logic [KIND_W-1:0] kind,
                                                     input logic [FILE_W-1:0] f,
                                                     input logic [PAGE_W-1:0] p);
    pool_reply_t r;
    int n, hit, s, i;
    bit found, any;
    logic [STAMP_W-1:0] age, best;
    r = '0;
    r.status = ST_ABSENT;
    n = slots_in_use();
    hit = -1;
    s = 0;
    for (i = 0; i < n; i++) begin
      if (hit < 0 && slot_used[i] && slot_file[i] == f && slot_page[i] == p) hit = i;
    end
    if (kind == K_READ || kind == K_WRITE) begin
      if (hit >= 0) begin
        s = hit;
        r.status = ST_HIT;
        slot_stamp[s] = use_count;
        use_count = use_count + 1;
      end else begin
        found = 1'b0;
        for (i = 0; i < n; i++) begin
          if (!found && !slot_used[i]) begin
            s = i;
            found = 1'b1;
          end
        end
        if (found) begin
          r.status = ST_FILL;
        end else begin
          // oldest unpinned slot, ages taken modulo the stamp width
          any = 1'b0;
          best = '0;
          for (i = 0; i < n; i++) begin
            age = use_count - slot_stamp[i];
            if (!slot_pinned[i] && (!any || age > best)) begin
              any = 1'b1;
              best = age;
              s = i;
            end
          end
          if (any) begin
            r.status = ST_EVICT;
            r.wb = 1'b1;
            r.wb_file = slot_file[s];
            r.wb_page = slot_page[s];
          end else begin
            r.status = ST_ALLPIN;
            s = 0;
          end
        end
        if (r.status == ST_FILL || r.status == ST_EVICT) begin
          r.fetch = 1'b1;
          slot_used[s] = 1'b1;
          slot_file[s] = f;
          slot_page[s] = p;
          slot_pinned[s] = 1'b0;
          slot_dirty[s] = 1'b0;
          slot_stamp[s] = use_count;
          use_count = use_count + 1;
        end
      end
      if (kind == K_WRITE && r.status != ST_ALLPIN) slot_dirty[s] = 1'b1;
    end else if ((kind == K_FLUSH || kind == K_PIN || kind == K_UNPIN ||
                  kind == K_REMOVE) && hit >= 0) begin
      s = hit;
      r.status = ST_HIT;
      case (kind)
        K_FLUSH: begin
          r.wb = 1'b1;
          r.wb_file = slot_file[s];
          r.wb_page = slot_page[s];
          slot_dirty[s] = 1'b0;
        end
        K_PIN: slot_pinned[s] = 1'b1;
        K_UNPIN: slot_pinned[s] = 1'b0;
        default: begin
          slot_used[s] = 1'b0;
          slot_pinned[s] = 1'b0;
          slot_dirty[s] = 1'b0;
        end
      endcase
    end
    r.slot = s[SLOT_W-1:0];
    return r;
  endfunction

  function automatic plan_row_t req_row(input logic [KIND_W-1:0] kind,
                                        input logic [FILE_W-1:0] f,
                                        input logic [PAGE_W-1:0] p);
    plan_row_t row;
    row = '{default: '0};
    row.kind = kind;
    row.file = f;
    row.page = p;
    return row;
  endfunction

  function automatic plan_row_t chk_row(input logic [KIND_W-1:0] kind,
                                        input logic [FILE_W-1:0] f,
                                        input logic [PAGE_W-1:0] p,
                                        input logic [SLOT_W-1:0] slot,
                                        input logic [STATUS_W-1:0] status,
                                        input logic fetch);
    plan_row_t row;
    row = req_row(kind, f, p);
    row.typed = 1'b1;
    row.want = '{slot: slot, status: status, fetch: fetch, default: '0};
    return row;
  endfunction

  function automatic plan_row_t cfg_row(input logic [ACT_W-1:0] act);
    plan_row_t row;
    row = '{default: '0};
    row.is_cfg = 1'b1;
    row.act = act;
    return row;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Offers one request after a random gap; predicts its reply on acceptance.
  task automatic send_request(input logic [KIND_W-1:0] kind, input logic [FILE_W-1:0] f,
                              input logic [PAGE_W-1:0] p, input bit typed,
                              input pool_reply_t want);
    int gap;
    pool_reply_t r;
    gap = no_gaps ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_file_id <= f;
    in_page_id <= p;
    @(posedge clk);
    while (!(in_valid && in_ready)) @(posedge clk);
    r = serve_page_request(kind, f, p);
    pending_replies.push_back(typed ? want : r);
    @(negedge clk);
  endtask

  task automatic drain_replies();
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_active_slots(input logic [ACT_W-1:0] act);
    drain_replies();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= act;
    active_cfg = act;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_random_request();
    int n, span, pick, roll;
    logic [KIND_W-1:0] kind;
    logic [FILE_W-1:0] f;
    logic [PAGE_W-1:0] p;
    n = slots_in_use();
    span = n + 2 + n / 2;
    if (span > POOL_N) span = POOL_N;
    pick = $urandom_range(0, span - 1);
    f = pool_file_ids[pick];
    p = pool_page_ids[pick];
    if ($urandom_range(0, 9) == 0) begin
      f = FILE_W'($urandom);
      p = $urandom;
    end
    roll = $urandom_range(0, 99);
    if (roll < 35) kind = K_READ;
    else if (roll < 60) kind = K_WRITE;
    else if (roll < 68) kind = K_FLUSH;
    else if (roll < 78) kind = K_PIN;
    else if (roll < 90) kind = K_UNPIN;
    else if (roll < 97) kind = K_REMOVE;
    else kind = roll[0] ? K_UNDEF_HI : K_UNDEF_LO;
    send_request(kind, f, p, 1'b0, '0);
  endtask

  // result side: random stalls, one long hold-off on request, field checks
  initial begin
    int w;
    pool_reply_t want;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      w = no_gaps ? 0 : $urandom_range(0, 7);
      if (hold_off > 0) begin
        w = hold_off;
        hold_off = 0;
      end
      if (w > 0) begin
        out_ready <= 1'b0;
        repeat (w) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
      if (pending_replies.size() == 0) begin
        $error("result with no request pending: slot %0d status %0d", out_slot, out_status);
        mismatches++;
      end else begin
        want = pending_replies.pop_front();
        check_field("slot", 32'(want.slot), 32'(out_slot));
        check_field("status", 32'(want.status), 32'(out_status));
        check_field("fetch_needed", 32'(want.fetch), 32'(out_fetch_needed));
        check_field("write_back_needed", 32'(want.wb), 32'(out_write_back_needed));
        check_field("write_back_file", 32'(want.wb_file), 32'(out_write_back_file));
        check_field("write_back_page", want.wb_page, out_write_back_page);
      end
      @(negedge clk);
    end
  end

  initial begin
    #4_000_000;
    $display("[page_buffer_lru_pin_dirty] ERROR");
    $finish;
  end

  initial begin
    logic [ACT_W-1:0] act_plan[9];
    plan_row_t row;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_kind = '0;
    in_file_id = '0;
    in_page_id = '0;
    for (int i = 0; i < NSLOT; i++) begin
      slot_used[i] = 1'b0;
      slot_file[i] = '0;
      slot_page[i] = '0;
      slot_pinned[i] = 1'b0;
      slot_dirty[i] = 1'b0;
      slot_stamp[i] = '0;
    end
    use_count = '0;
    active_cfg = ACT_RESET;
    for (int i = 0; i < POOL_N; i++) begin
      pool_file_ids[i] = FILE_W'($urandom);
      pool_page_ids[i] = $urandom;
    end
    act_plan = '{5'd2, 5'd16, 5'd1, 5'd31, 5'd0, 5'd5, 5'd17, 5'd3, 5'd16};

    directed_plan.push_back(chk_row(K_READ, 16'h0000, 32'h0000_0000, 4'd0, ST_FILL, 1'b1));
    directed_plan.push_back(chk_row(K_READ, 16'hFFFF, 32'hFFFF_FFFF, 4'd1, ST_FILL, 1'b1));
    directed_plan.push_back(chk_row(K_FLUSH, 16'h0001, 32'h0000_0001, 4'd0, ST_ABSENT, 1'b0));
    directed_plan.push_back(chk_row(K_UNDEF_LO, 16'h0000, 32'h0000_0000, 4'd0, ST_ABSENT,
                                    1'b0));
    directed_plan.push_back(chk_row(K_UNDEF_HI, 16'hFFFF, 32'hFFFF_FFFF, 4'd0, ST_ABSENT,
                                    1'b0));
    directed_plan.push_back(cfg_row(5'd2));
    directed_plan.push_back(req_row(K_WRITE, 16'h0000, 32'h0000_0000));
    directed_plan.push_back(req_row(K_FLUSH, 16'h0000, 32'h0000_0000));
    directed_plan.push_back(req_row(K_PIN, 16'h0000, 32'h0000_0000));
    directed_plan.push_back(req_row(K_PIN, 16'hFFFF, 32'hFFFF_FFFF));
    // both slots pinned: nothing can be evicted
    directed_plan.push_back(chk_row(K_READ, 16'h0002, 32'h0000_0002, 4'd0, ST_ALLPIN, 1'b0));
    directed_plan.push_back(chk_row(K_WRITE, 16'h0002, 32'h0000_0002, 4'd0, ST_ALLPIN, 1'b0));
    directed_plan.push_back(req_row(K_UNPIN, 16'hFFFF, 32'hFFFF_FFFF));
    directed_plan.push_back(req_row(K_WRITE, 16'h0003, 32'h0000_0003));
    directed_plan.push_back(req_row(K_REMOVE, 16'h0003, 32'h0000_0003));
    directed_plan.push_back(req_row(K_READ, 16'h0004, 32'h0000_0004));
    directed_plan.push_back(chk_row(K_REMOVE, 16'h0009, 32'h0000_0009, 4'd0, ST_ABSENT, 1'b0));
    directed_plan.push_back(chk_row(K_UNPIN, 16'h0009, 32'h0000_0009, 4'd0, ST_ABSENT, 1'b0));
    directed_plan.push_back(chk_row(K_PIN, 16'h0009, 32'h0000_0009, 4'd0, ST_ABSENT, 1'b0));
    // zero slots behaves as one
    directed_plan.push_back(cfg_row(5'd0));
    directed_plan.push_back(req_row(K_READ, 16'h0000, 32'h0000_0000));
    directed_plan.push_back(chk_row(K_READ, 16'h0005, 32'h0000_0005, 4'd0, ST_ALLPIN, 1'b0));
    directed_plan.push_back(req_row(K_UNPIN, 16'h0000, 32'h0000_0000));
    directed_plan.push_back(req_row(K_READ, 16'h0005, 32'h0000_0005));
    // above the built count clamps; hidden slots kept their pages
    directed_plan.push_back(cfg_row(5'd31));
    directed_plan.push_back(req_row(K_READ, 16'h0004, 32'h0000_0004));
    directed_plan.push_back(req_row(K_WRITE, 16'h8000, 32'h8000_0000));
    directed_plan.push_back(req_row(K_FLUSH, 16'hFFFF, 32'hFFFF_FFFF));

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_plan[k]) begin
      row = directed_plan[k];
      if (row.is_cfg) set_active_slots(row.act);
      else send_request(row.kind, row.file, row.page, row.typed, row.want);
    end

    for (int ph = 0; ph < 9; ph++) begin
      set_active_slots(act_plan[ph]);
      no_gaps = (ph == 1 || ph == 6);
      if (ph == 3) hold_off = 400;
      for (int j = 0; j < PHASE_REQS; j++) begin
        if (ph == 5 && j == PHASE_REQS / 2) drain_replies();
        send_random_request();
      end
    end

    drain_replies();
    repeat (24) @(posedge clk);
    if (mismatches == 0) begin
      $display("[page_buffer_lru_pin_dirty] OK");
    end else begin
      $display("[page_buffer_lru_pin_dirty] ERROR");
    end
    $finish;
  end

endmodule
